FILE: rtl/icofg_pkg.sv
// Package for the icosphere face generator: sequencer states and base icosahedron tables.
package icofg_pkg;

  localparam int MAX_SUBDIV_DEF       = 7;
  localparam int NORMAL_FRAC_BITS_DEF = 16;
  localparam int RADIUS_W             = 20;
  localparam int DEPTH_W              = 3;
  localparam int COLOR_W              = 32;
  localparam int INDEX_W              = 19;
  localparam int POS_W                = 22;
  localparam int NORM_W               = 18;
  localparam int BASE_FACES           = 20;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_DEPTH  = 2'd1;
  localparam logic [1:0] REG_COLOR  = 2'd2;

  localparam logic [1:0] CHILD_A   = 2'd0;
  localparam logic [1:0] CHILD_B   = 2'd1;
  localparam logic [1:0] CHILD_C   = 2'd2;
  localparam logic [1:0] CHILD_MID = 2'd3;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SUM   = 8'b0000_0010,
    ST_SQ    = 8'b0000_0100,
    ST_SQRT  = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_CHILD = 8'b0010_0000,
    ST_POS   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  // coordinate pattern of base vertex: +-1 small constant, +-2 big constant
  function automatic logic signed [2:0] base_pat(input logic [3:0] vi, input logic [1:0] c);
    logic signed [2:0] p [12][3];
    p[0]  = '{3'sd1, 3'sd0, -3'sd2};  p[1]  = '{-3'sd1, 3'sd0, -3'sd2};
    p[2]  = '{3'sd1, 3'sd0, 3'sd2};   p[3]  = '{-3'sd1, 3'sd0, 3'sd2};
    p[4]  = '{3'sd0, -3'sd2, -3'sd1}; p[5]  = '{3'sd0, -3'sd2, 3'sd1};
    p[6]  = '{3'sd0, 3'sd2, -3'sd1};  p[7]  = '{3'sd0, 3'sd2, 3'sd1};
    p[8]  = '{-3'sd2, -3'sd1, 3'sd0}; p[9]  = '{3'sd2, -3'sd1, 3'sd0};
    p[10] = '{-3'sd2, 3'sd1, 3'sd0};  p[11] = '{3'sd2, 3'sd1, 3'sd0};
    if (vi < 4'd12 && c < 2'd3) begin
      return p[vi][c];
    end
    return 3'sd0;
  endfunction

  function automatic logic [3:0] base_face(input logic [4:0] f, input logic [1:0] k);
    logic [3:0] t [20][3];
    t[0]  = '{4'd0, 4'd1, 4'd6};   t[1]  = '{4'd0, 4'd4, 4'd1};
    t[2]  = '{4'd0, 4'd9, 4'd4};   t[3]  = '{4'd2, 4'd7, 4'd3};
    t[4]  = '{4'd4, 4'd5, 4'd8};   t[5]  = '{4'd4, 4'd8, 4'd1};
    t[6]  = '{4'd5, 4'd2, 4'd3};   t[7]  = '{4'd5, 4'd3, 4'd8};
    t[8]  = '{4'd6, 4'd1, 4'd10};  t[9]  = '{4'd7, 4'd2, 4'd11};
    t[10] = '{4'd7, 4'd6, 4'd10};  t[11] = '{4'd7, 4'd10, 4'd3};
    t[12] = '{4'd7, 4'd11, 4'd6};  t[13] = '{4'd8, 4'd3, 4'd10};
    t[14] = '{4'd8, 4'd10, 4'd1};  t[15] = '{4'd9, 4'd0, 4'd11};
    t[16] = '{4'd9, 4'd2, 4'd5};   t[17] = '{4'd9, 4'd5, 4'd4};
    t[18] = '{4'd9, 4'd11, 4'd2};  t[19] = '{4'd11, 4'd0, 4'd6};
    if (f < 5'(BASE_FACES) && k < 2'd3) begin
      return t[f][k];
    end
    return 4'd0;
  endfunction

endpackage

FILE: rtl/icosphere_face_generator_top.sv
// Icosphere face generator: index to three vertices through one shared arithmetic unit.
//
// Each face index gives three vertex transfers (a, b, c; tlast on c). The block
// takes one index at a time and is not ready until the third vertex is taken.
// The work per face runs through one shared multiplier and one shared compare-subtract
// unit: per subdivision level, each edge midpoint is summed, squared,
// normalised by a square root and a divide per coordinate, and a child face is
// picked; then each vertex is scaled by the radius and held until it is taken.
module icosphere_face_generator_top
  import icofg_pkg::*;
#(
  parameter int MAX_SUBDIV       = MAX_SUBDIV_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // face_index[18:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z (22 each), norm_x, norm_y, norm_z (18 each), color_out, face_total
  output logic [175:0] m_axis_tdata,
  output logic         m_axis_tuser,   // index_error
  output logic         m_axis_tlast    // last_vertex
);

  localparam int F   = NORMAL_FRAC_BITS;
  localparam int NW  = F + 2;
  localparam int SW  = F + 3;
  localparam int LW  = 2 * F + 4;
  localparam int RW  = F + 2;
  localparam int OW  = (SW > RADIUS_W) ? SW : RADIUS_W;
  localparam int IW  = $clog2(LW);
  localparam int LVW = (MAX_SUBDIV > 0) ? $clog2(MAX_SUBDIV + 1) : 1;
  localparam int SH  = 30 - F;
  localparam longint HALF = (SH > 0) ? (64'sd1 <<< (SH - 1)) : 64'sd0;
  localparam longint KS64 = (64'sd564499483 + HALF) >>> SH;
  localparam longint KB64 = (64'sd913379351 + HALF) >>> SH;
  localparam logic signed [NW-1:0] KS = NW'(KS64);
  localparam logic signed [NW-1:0] KB = NW'(KB64);
  localparam logic [F:0] QMAX = (F+1)'(1) << F;

  state_t state;
  logic [RADIUS_W-1:0] radius;
  logic [DEPTH_W-1:0]  depth;
  logic [COLOR_W-1:0]  color;

  logic signed [NW-1:0] v   [3][3];
  logic signed [NW-1:0] mid [3][3];
  logic signed [SW-1:0] s   [3];
  logic [LW-1:0] acc;
  logic [LW-1:0] rsq;
  logic [RW-1:0] root;
  logic [LW-1:0] rem;
  logic [F:0]    q;
  logic [IW-1:0] it;
  logic [1:0]    e, c, k;
  logic [LVW-1:0] left;
  logic [INDEX_W-1:0] idx;
  logic [INDEX_W-1:0] total;
  logic err;

  logic signed [POS_W-1:0]  o_pos  [3];
  logic signed [NORM_W-1:0] o_norm [3];
  logic o_last;

  function automatic logic signed [NW-1:0] coord(input logic signed [2:0] p);
    case (p)
      3'sd1:   return KS;
      -3'sd1:  return -KS;
      3'sd2:   return KB;
      -3'sd2:  return -KB;
      default: return '0;
    endcase
  endfunction

  // accept-time decode
  logic [DEPTH_W-1:0] d_eff;
  logic [63:0] total64;
  logic [INDEX_W-1:0] in_idx;
  logic [4:0] in_face;
  logic in_err;
  always_comb begin
    in_idx  = s_axis_tdata[INDEX_W-1:0];
    d_eff   = (int'(depth) > MAX_SUBDIV) ? DEPTH_W'(MAX_SUBDIV) : depth;
    total64 = 64'd20 << (2 * d_eff);
    in_err  = {45'd0, in_idx} >= total64;
    in_face = 5'(in_idx >> (2 * d_eff));
  end

  // shared multiplier and compare-subtract
  logic [1:0] eb;
  logic [SW-1:0] smag;
  logic [NW-1:0] vmag;
  logic [OW-1:0] ma, mb;
  logic [2*OW-1:0] prod;
  logic [LW-1:0] bitv, sa, sb, num;
  logic [LW:0]   diff;
  logic ge;
  logic [F:0] qf, qs;
  logic [1:0] ch;
  logic [63:0] pmag, pval;
  logic [2*OW-1:0] pround;
  always_comb begin
    eb   = (e == 2'd2) ? 2'd0 : e + 2'd1;
    smag = s[c][SW-1] ? SW'(-s[c]) : SW'(s[c]);
    vmag = v[k][c][NW-1] ? NW'(-v[k][c]) : NW'(v[k][c]);
    ma   = (state == ST_POS) ? OW'(vmag) : OW'(smag);
    mb   = (state == ST_POS) ? OW'(radius) : OW'(smag);
    prod = ma * mb;
    bitv = LW'(1) << (2 * it);
    num  = (LW'(smag) << F) + LW'(root >> 1);
    if (state == ST_SQRT) begin
      sa = rem;
      sb = rsq + bitv;
    end else begin
      sa = (int'(it) == F) ? num : rem;
      sb = LW'(root) << it;
    end
    diff = {1'b0, sa} - {1'b0, sb};
    ge   = !diff[LW];
    qf   = {q[F-1:0], ge};
    qs   = (qf > QMAX) ? QMAX : qf;
    ch   = 2'(idx >> (2 * (int'(left) - 1)));
    pround = prod + ((2*OW)'(1) << (F - 1));
    pmag = 64'(pround >> F);
    pval = v[k][c][NW-1] ? (64'd0 - pmag) : pmag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      radius <= RADIUS_W'(256);
      depth  <= '0;
      color  <= '1;
      it <= '0; e <= '0; c <= '0; k <= '0; left <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_RADIUS: radius <= cfg_wdata[RADIUS_W-1:0];
          REG_DEPTH:  depth  <= cfg_wdata[DEPTH_W-1:0];
          REG_COLOR:  color  <= cfg_wdata[COLOR_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            idx   <= in_idx;
            total <= total64[INDEX_W-1:0];
            err   <= in_err;
            left  <= LVW'(d_eff);
            e <= '0; c <= '0; k <= '0;
            for (int i = 0; i < 3; i++) begin
              for (int j = 0; j < 3; j++) begin
                v[i][j] <= in_err ? '0 : coord(base_pat(base_face(in_face, 2'(i)), 2'(j)));
              end
            end
            state <= (in_err || d_eff == '0) ? ST_POS : ST_SUM;
          end
        end
        ST_SUM: begin
          for (int j = 0; j < 3; j++) begin
            s[j] <= SW'(v[e][j]) + SW'(v[eb][j]);
          end
          acc <= '0;
          c <= '0;
          state <= ST_SQ;
        end
        ST_SQ: begin
          if (c == 2'd2) begin
            rem   <= acc + LW'(prod);
            rsq   <= '0;
            it    <= IW'(F + 1);
            c     <= '0;
            state <= ST_SQRT;
          end else begin
            acc <= acc + LW'(prod);
            c   <= c + 2'd1;
          end
        end
        ST_SQRT: begin
          if (ge) begin
            rem <= diff[LW-1:0];
            rsq <= (rsq >> 1) + bitv;
          end else begin
            rsq <= rsq >> 1;
          end
          if (it == '0) begin
            root <= ge ? RW'((rsq >> 1) + bitv) : RW'(rsq >> 1);
            if (!ge && (rsq >> 1) == '0) begin
              for (int j = 0; j < 3; j++) mid[e][j] <= '0;
              e     <= e + 2'd1;
              state <= (e == 2'd2) ? ST_CHILD : ST_SUM;
            end else begin
              it    <= IW'(F);
              q     <= '0;
              state <= ST_DIV;
            end
          end else begin
            it <= it - 1'b1;
          end
        end
        ST_DIV: begin
          rem <= ge ? diff[LW-1:0] : sa;
          q   <= qf;
          if (it == '0) begin
            mid[e][c] <= s[c][SW-1] ? -NW'(qs) : NW'(qs);
            it <= IW'(F);
            q  <= '0;
            if (c == 2'd2) begin
              c     <= '0;
              e     <= e + 2'd1;
              state <= (e == 2'd2) ? ST_CHILD : ST_SUM;
            end else begin
              c <= c + 2'd1;
            end
          end else begin
            it <= it - 1'b1;
          end
        end
        ST_CHILD: begin
          case (ch)
            CHILD_A:   begin v[1] <= mid[0]; v[2] <= mid[2]; end
            CHILD_B:   begin v[0] <= v[1]; v[1] <= mid[1]; v[2] <= mid[0]; end
            CHILD_C:   begin v[0] <= v[2]; v[1] <= mid[2]; v[2] <= mid[1]; end
            default:   begin v[0] <= mid[0]; v[1] <= mid[1]; v[2] <= mid[2]; end
          endcase
          e    <= '0;
          left <= left - 1'b1;
          state <= (left == LVW'(1)) ? ST_POS : ST_SUM;
        end
        ST_POS: begin
          o_pos[c]  <= pval[POS_W-1:0];
          o_norm[c] <= NORM_W'(64'(v[k][c]));
          o_last    <= (k == 2'd2);
          if (c == 2'd2) begin
            c     <= '0;
            state <= ST_OUT;
          end else begin
            c <= c + 2'd1;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            k     <= (k == 2'd2) ? 2'd0 : k + 2'd1;
            state <= (k == 2'd2) ? ST_IDLE : ST_POS;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tlast  = o_last;
  assign m_axis_tuser  = err;
  assign m_axis_tdata  = {5'd0, total, color, o_norm[2], o_norm[1], o_norm[0],
                          o_pos[2], o_pos[1], o_pos[0]};

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready while a face is in progress");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[119:0] == '0))
    else $error("out-of-range face with nonzero vertex");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not idle after last vertex");

  a_not_both: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while vertex pending");

endmodule
